// ===== rtl/core/rate_limited_zero_crossing_pulser_macros.svh =====
// Assertion helpers shared by the pulser RTL.
`ifndef RATE_LIMITED_ZERO_CROSSING_PULSER_MACROS_SVH
`define RATE_LIMITED_ZERO_CROSSING_PULSER_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define RLZC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define RLZC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/rlzc_pkg.sv =====
package rlzc_pkg;

  // Item kinds, shared by the input and result channels.
  localparam logic KIND_HEADER = 1'b0;
  localparam logic KIND_SAMPLE = 1'b1;

  localparam int CFG_IDX_W = 4;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CROSSING_ENABLE   = 4'd0,
    REG_HOLDOFF_US        = 4'd1,
    REG_PULSE_LEN_US      = 4'd2,
    REG_AMPLITUDE_FLOOR   = 4'd3,
    REG_CAPTURE_SPAN_US   = 4'd4,
    REG_SAMPLE_SPACING_US = 4'd5,
    REG_ZERO_LEVEL        = 4'd6,
    REG_IMBALANCE_LIMIT   = 4'd7
  } cfg_reg_e;

  localparam logic        RST_CROSSING_ENABLE   = 1'b1;
  localparam logic [31:0] RST_HOLDOFF_US        = 32'd0;
  localparam logic [15:0] RST_PULSE_LEN_US      = 16'd100;
  localparam logic [15:0] RST_AMPLITUDE_FLOOR   = 16'd3277;
  localparam logic [31:0] RST_CAPTURE_SPAN_US   = 32'd0;
  localparam logic [15:0] RST_SAMPLE_SPACING_US = 16'd0;
  localparam logic [15:0] RST_ZERO_LEVEL        = 16'd2048;
  localparam logic [15:0] RST_IMBALANCE_LIMIT   = 16'd50;

  typedef struct packed {
    logic        crossing_enable;
    logic [31:0] holdoff_us;
    logic [15:0] pulse_len_us;
    logic [15:0] amplitude_floor;
    logic [31:0] capture_span_us;
    logic [15:0] sample_spacing_us;
    logic [15:0] zero_level;
    logic [15:0] imbalance_limit;
  } cfg_t;

  // Per-channel crossing history, one memory word per channel.
  typedef struct packed {
    logic        [31:0] last_pulse_time;
    logic signed [16:0] prev_value;
    logic signed [16:0] prev_prev_value;
  } chan_state_t;

endpackage

// ===== rtl/core/rate_limited_zero_crossing_pulser.sv =====
// An item transfers into stage 1 together with its memory reads; the result register loads
// from stage 1 once the result register is free, so a stalled result holds the item there.
// Throughput: one item per cycle; each channel memory does one read-modify-write per cycle and
// forwards the write of one item into the read of the next. Input stalls only echo result_stall.
// Reset (rst, synchronous): configuration takes its defaults, no buffer is active, and both
// channel memories read as zero through per-entry written bits; items are accepted at once.
module rate_limited_zero_crossing_pulser
  import rlzc_pkg::*;
#(
  parameter int CHANNELS = 4
) (
  input  logic                 clk,
  input  logic                 rst,
  // configuration write channel
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data,
  // item channel
  input  logic                 item_valid,
  output logic                 item_stall,
  input  logic                 kind,
  input  logic [1:0]           channel,
  input  logic [31:0]          end_time_us,
  input  logic [15:0]          amplitude,
  input  logic [15:0]          above_count,
  input  logic [15:0]          below_count,
  input  logic [15:0]          sample,
  // result channel
  output logic                 result_valid,
  input  logic                 result_stall,
  output logic                 result_kind,
  output logic [15:0]          amplitude_out,
  output logic                 buffer_taken,
  output logic                 pulse,
  output logic [31:0]          pulse_time_us,
  output logic [1:0]           pulse_channel,
  output logic [15:0]          pulse_width
);

  localparam int IDX_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int STATE_W = $bits(chan_state_t);

  cfg_t cfg;

  // Configuration never back-pressures.
  assign cfg_ready = 1'b1;

  rlzc_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // ---------------------------------------------------------------------------
  // Stage 1: item registers, aligned with the memory read data.
  // ---------------------------------------------------------------------------
  logic        s1_valid;
  logic        s1_kind;
  logic [1:0]  s1_channel;
  logic [31:0] s1_end_time;
  logic [15:0] s1_amplitude;
  logic [15:0] s1_above;
  logic [15:0] s1_below;
  logic [15:0] s1_sample;

  logic item_xfer;
  logic s1_adv;
  logic res_free;

  // The result register frees up when empty or when its result transfers this cycle.
  assign res_free   = !result_valid || !result_stall;
  assign s1_adv     = s1_valid && res_free;
  assign item_stall = s1_valid && !res_free;
  assign item_xfer  = item_valid && !item_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (item_xfer) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_xfer) begin
      s1_kind      <= kind;
      s1_channel   <= channel;
      s1_end_time  <= end_time_us;
      s1_amplitude <= amplitude;
      s1_above     <= above_count;
      s1_below     <= below_count;
      s1_sample    <= sample;
    end
  end

  // ---------------------------------------------------------------------------
  // Buffer-level state: which channel is being examined and where in time.
  // ---------------------------------------------------------------------------
  logic        buffer_active;
  logic        buffer_active_next;
  logic [1:0]  active_channel;
  logic [1:0]  active_channel_next;
  logic        lopsided;
  logic        lopsided_next;
  logic [31:0] next_sample_time;
  logic [31:0] next_sample_time_next;

  // ---------------------------------------------------------------------------
  // Channel addressing. Channel codes may exceed the memory depth, so widen first.
  // ---------------------------------------------------------------------------
  logic [IDX_W+1:0] item_ch_wide;
  logic [IDX_W+1:0] s1_ch_wide;
  logic [IDX_W+1:0] act_ch_wide;
  logic [IDX_W-1:0] item_addr;
  logic [IDX_W-1:0] s1_addr;
  logic [IDX_W-1:0] act_addr;
  logic [IDX_W-1:0] state_rd_addr;
  logic             s1_ch_ok;

  assign item_ch_wide = {{IDX_W{1'b0}}, channel};
  assign s1_ch_wide   = {{IDX_W{1'b0}}, s1_channel};
  assign act_ch_wide  = {{IDX_W{1'b0}}, active_channel};
  assign item_addr    = item_ch_wide[IDX_W-1:0];
  assign s1_addr      = s1_ch_wide[IDX_W-1:0];
  assign act_addr     = act_ch_wide[IDX_W-1:0];
  assign s1_ch_ok     = s1_ch_wide < (IDX_W+2)'(CHANNELS);

  // A header still in stage 1 decides the channel of the samples behind it.
  assign state_rd_addr = (s1_valid && (s1_kind == KIND_HEADER)) ? s1_addr : act_addr;

  // ---------------------------------------------------------------------------
  // Channel memories: last buffer end time, and the crossing history.
  // ---------------------------------------------------------------------------
  logic              time_wr_en;
  logic [31:0]       last_buffer_time;
  logic              state_wr_en;
  chan_state_t       state_rd;
  chan_state_t       state_wr;
  logic [STATE_W-1:0] state_rd_bits;

  rlzc_chan_mem #(
    .DEPTH (CHANNELS),
    .WIDTH (32)
  ) u_time_mem (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (item_xfer),
    .rd_addr (item_addr),
    .wr_en   (time_wr_en),
    .wr_addr (s1_addr),
    .wr_data (s1_end_time),
    .rd_data (last_buffer_time)
  );

  rlzc_chan_mem #(
    .DEPTH (CHANNELS),
    .WIDTH (STATE_W)
  ) u_state_mem (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (item_xfer),
    .rd_addr (state_rd_addr),
    .wr_en   (state_wr_en),
    .wr_addr (act_addr),
    .wr_data (state_wr),
    .rd_data (state_rd_bits)
  );

  assign state_rd = chan_state_t'(state_rd_bits);

  // ---------------------------------------------------------------------------
  // Header evaluation: freshness, floor, imbalance.
  // ---------------------------------------------------------------------------
  logic        hdr_fresh;
  logic        hdr_loud;
  logic        hdr_taken;
  logic [15:0] count_gap;

  assign hdr_fresh = s1_ch_ok && (s1_end_time > last_buffer_time);
  assign hdr_loud  = s1_amplitude >= cfg.amplitude_floor;
  assign hdr_taken = hdr_fresh && hdr_loud && cfg.crossing_enable;
  assign count_gap = (s1_above >= s1_below) ? (s1_above - s1_below) : (s1_below - s1_above);

  // ---------------------------------------------------------------------------
  // Sample evaluation: rising crossing, slope check, minimum period.
  // ---------------------------------------------------------------------------
  logic signed [16:0] value;
  logic               crossing;
  logic [31:0]        since_pulse;
  logic               fire;

  assign value       = $signed({1'b0, cfg.zero_level}) - $signed({1'b0, s1_sample});
  assign crossing    = (value > 17'sd0) && (state_rd.prev_value <= 17'sd0) &&
                       (!lopsided || (state_rd.prev_value >= state_rd.prev_prev_value));
  assign since_pulse = next_sample_time - state_rd.last_pulse_time;
  assign fire        = buffer_active && crossing && (since_pulse >= cfg.holdoff_us);

  assign time_wr_en  = s1_adv && (s1_kind == KIND_HEADER) && hdr_fresh;
  assign state_wr_en = s1_adv && (s1_kind == KIND_SAMPLE) && buffer_active;

  // Shift the history by one sample; stamp the pulse time only when it fires.
  always_comb begin
    state_wr.last_pulse_time = fire ? next_sample_time : state_rd.last_pulse_time;
    state_wr.prev_prev_value = state_rd.prev_value;
    state_wr.prev_value      = value;
  end

  // Next buffer-level state.
  always_comb begin
    buffer_active_next    = buffer_active;
    active_channel_next   = active_channel;
    lopsided_next         = lopsided;
    next_sample_time_next = next_sample_time;
    if (s1_adv) begin
      if (s1_kind == KIND_HEADER) begin
        // every header closes the previous buffer; a taken one opens a new one
        buffer_active_next = hdr_taken;
        if (hdr_taken) begin
          active_channel_next   = s1_channel;
          lopsided_next         = count_gap > cfg.imbalance_limit;
          next_sample_time_next = s1_end_time - cfg.capture_span_us;
        end
      end else if (buffer_active) begin
        next_sample_time_next = next_sample_time + {16'd0, cfg.sample_spacing_us};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      buffer_active    <= 1'b0;
      active_channel   <= '0;
      lopsided         <= 1'b0;
      next_sample_time <= '0;
    end else begin
      buffer_active    <= buffer_active_next;
      active_channel   <= active_channel_next;
      lopsided         <= lopsided_next;
      next_sample_time <= next_sample_time_next;
    end
  end

  // ---------------------------------------------------------------------------
  // Result register: holds a finished result while the receiver stalls; stage 1 waits behind it.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (s1_adv) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      result_kind <= s1_kind;
      if (s1_kind == KIND_HEADER) begin
        // a fresh header under the floor reports silence
        amplitude_out <= (hdr_fresh && !hdr_loud) ? 16'd0 : s1_amplitude;
        buffer_taken  <= hdr_taken;
        pulse         <= 1'b0;
        pulse_time_us <= '0;
        pulse_channel <= '0;
        pulse_width   <= '0;
      end else begin
        amplitude_out <= '0;
        buffer_taken  <= 1'b0;
        pulse         <= fire;
        pulse_time_us <= fire ? (next_sample_time + cfg.capture_span_us) : 32'd0;
        pulse_channel <= fire ? active_channel : 2'd0;
        pulse_width   <= fire ? cfg.pulse_len_us : 16'd0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  logic act_ch_ok;
  logic hdr_open;
  logic res_pulse;
  logic res_quiet;
  logic quiet_zero;

  assign act_ch_ok  = act_ch_wide < (IDX_W+2)'(CHANNELS);
  assign hdr_open   = s1_adv && (s1_kind == KIND_HEADER) && hdr_taken;
  assign res_pulse  = result_valid && pulse;
  assign res_quiet  = result_valid && !pulse;
  assign quiet_zero = (pulse_time_us == 32'd0) && (pulse_width == 16'd0);

  `include "rate_limited_zero_crossing_pulser_macros.svh"

  `RLZC_ASSERT_NEXT(a_taken_opens_buffer, hdr_open, buffer_active, "buffer not opened")
  `RLZC_ASSERT_NOW(a_active_channel_ok, buffer_active, act_ch_ok, "active channel out of range")
  `RLZC_ASSERT_NOW(a_pulse_on_sample, res_pulse, result_kind == KIND_SAMPLE, "pulse on header")
  `RLZC_ASSERT_NOW(a_quiet_fields_zero, res_quiet, quiet_zero, "pulse fields without pulse")

endmodule

// ===== rtl/core/rlzc_cfg.sv =====
module rlzc_cfg
  import rlzc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data,
  output cfg_t                 cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.crossing_enable   <= RST_CROSSING_ENABLE;
      cfg.holdoff_us        <= RST_HOLDOFF_US;
      cfg.pulse_len_us      <= RST_PULSE_LEN_US;
      cfg.amplitude_floor   <= RST_AMPLITUDE_FLOOR;
      cfg.capture_span_us   <= RST_CAPTURE_SPAN_US;
      cfg.sample_spacing_us <= RST_SAMPLE_SPACING_US;
      cfg.zero_level        <= RST_ZERO_LEVEL;
      cfg.imbalance_limit   <= RST_IMBALANCE_LIMIT;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_CROSSING_ENABLE:   cfg.crossing_enable   <= cfg_data[0];
        REG_HOLDOFF_US:        cfg.holdoff_us        <= cfg_data;
        REG_PULSE_LEN_US:      cfg.pulse_len_us      <= cfg_data[15:0];
        REG_AMPLITUDE_FLOOR:   cfg.amplitude_floor   <= cfg_data[15:0];
        REG_CAPTURE_SPAN_US:   cfg.capture_span_us   <= cfg_data;
        REG_SAMPLE_SPACING_US: cfg.sample_spacing_us <= cfg_data[15:0];
        REG_ZERO_LEVEL:        cfg.zero_level        <= cfg_data[15:0];
        REG_IMBALANCE_LIMIT:   cfg.imbalance_limit   <= cfg_data[15:0];
        default: begin
          // drop writes to unmapped indexes
        end
      endcase
    end
  end

endmodule

// ===== rtl/core/rlzc_chan_mem.sv =====
module rlzc_chan_mem
  import rlzc_pkg::*;
#(
  parameter int DEPTH = 4,
  parameter int WIDTH = 32
) (
  input  logic                                        clk,
  input  logic                                        rst,
  input  logic                                        rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  input  logic                                        wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                            wr_data,
  output logic [WIDTH-1:0]                            rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [DEPTH-1:0] written;
  logic [WIDTH-1:0] rd_q;
  logic             rd_written;
  logic             fwd_sel;
  logic [WIDTH-1:0] fwd_data;

  // Storage and registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  // Hold a copy of a write that lands on the entry being read in the same cycle.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      fwd_data <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      written    <= '0;
      rd_written <= 1'b0;
      fwd_sel    <= 1'b0;
    end else begin
      if (wr_en) begin
        written[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_written <= written[rd_addr];
        fwd_sel    <= wr_en && (wr_addr == rd_addr);
      end
    end
  end

  // Entries never written since reset read as zero.
  always_comb begin
    if (fwd_sel) begin
      rd_data = fwd_data;
    end else if (rd_written) begin
      rd_data = rd_q;
    end else begin
      rd_data = '0;
    end
  end

endmodule

// ===== tb/zero_crossing_checker.sv =====
module zero_crossing_checker
  import rlzc_pkg::*;
#(
  parameter int CHANNELS = 4
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data,
  input  logic                 item_valid,
  input  logic                 item_stall,
  input  logic                 kind,
  input  logic [1:0]           channel,
  input  logic [31:0]          end_time_us,
  input  logic [15:0]          amplitude,
  input  logic [15:0]          above_count,
  input  logic [15:0]          below_count,
  input  logic [15:0]          sample,
  input  logic                 result_valid,
  input  logic                 result_stall,
  input  logic                 result_kind,
  input  logic [15:0]          amplitude_out,
  input  logic                 buffer_taken,
  input  logic                 pulse,
  input  logic [31:0]          pulse_time_us,
  input  logic [1:0]           pulse_channel,
  input  logic [15:0]          pulse_width,
  output int                   failures,
  output int                   outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic        kind;
    logic [15:0] amplitude;
    logic        taken;
    logic        pulse;
    logic [31:0] time_us;
    logic [1:0]  channel;
    logic [15:0] width;
  } answer_t;

  cfg_t               regs;
  logic [31:0]        buf_end_time    [CHANNELS];
  logic [31:0]        pulse_time_last [CHANNELS];
  logic signed [16:0] level_now       [CHANNELS];
  logic signed [16:0] level_before    [CHANNELS];
  logic [1:0]         armed_channel;
  logic               armed;
  logic               skewed;
  logic [31:0]        sample_clock;
  answer_t            answers_due [$];

  // Advance the channel history by one item and return the answer it earns.
  function automatic answer_t predict_answer(input logic k, input logic [1:0] ch,
      input logic [31:0] end_t, input logic [15:0] amp, input logic [15:0] above,
      input logic [15:0] below, input logic [15:0] smp);
    answer_t            ans;
    logic [15:0]        spread;
    logic signed [16:0] level;
    logic signed [16:0] last_level;
    logic signed [16:0] older_level;
    logic [31:0]        stamp;
    ans = '0;
    ans.kind = k;
    if (k == KIND_HEADER) begin
      armed = 1'b0;
      if (ch >= CHANNELS || end_t <= buf_end_time[ch]) begin
        ans.amplitude = amp;
      end else begin
        buf_end_time[ch] = end_t;
        if (amp >= regs.amplitude_floor) begin
          ans.amplitude = amp;
          if (regs.crossing_enable) begin
            spread = (above >= below) ? above - below : below - above;
            skewed = spread > regs.imbalance_limit;
            armed_channel = ch;
            sample_clock = end_t - regs.capture_span_us;
            armed = 1'b1;
            ans.taken = 1'b1;
          end
        end
      end
    end else if (armed) begin
      level = $signed({1'b0, regs.zero_level}) - $signed({1'b0, smp});
      last_level = level_now[armed_channel];
      older_level = level_before[armed_channel];
      stamp = sample_clock;
      // rising crossing, held back on lopsided buffers unless the trend is non-falling
      if (level > 0 && last_level <= 0 && (!skewed || last_level >= older_level) &&
          stamp - pulse_time_last[armed_channel] >= regs.holdoff_us) begin
        pulse_time_last[armed_channel] = stamp;
        ans.pulse = 1'b1;
        ans.time_us = stamp + regs.capture_span_us;
        ans.channel = armed_channel;
        ans.width = regs.pulse_len_us;
      end
      level_before[armed_channel] = last_level;
      level_now[armed_channel] = level;
      sample_clock = stamp + regs.sample_spacing_us;
    end
    return ans;
  endfunction

  function automatic int field_differs(input string name, input logic [31:0] want,
      input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk) begin
    answer_t want;
    int      bad;
    bad = 0;
    if (rst) begin
      regs = '{crossing_enable: RST_CROSSING_ENABLE, holdoff_us: RST_HOLDOFF_US,
               pulse_len_us: RST_PULSE_LEN_US, amplitude_floor: RST_AMPLITUDE_FLOOR,
               capture_span_us: RST_CAPTURE_SPAN_US,
               sample_spacing_us: RST_SAMPLE_SPACING_US, zero_level: RST_ZERO_LEVEL,
               imbalance_limit: RST_IMBALANCE_LIMIT};
      for (int c = 0; c < CHANNELS; c++) begin
        buf_end_time[c] = '0;
        pulse_time_last[c] = '0;
        level_now[c] = '0;
        level_before[c] = '0;
      end
      armed_channel = '0;
      armed = 1'b0;
      skewed = 1'b0;
      sample_clock = '0;
      answers_due.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_CROSSING_ENABLE:   regs.crossing_enable = cfg_data[0];
          REG_HOLDOFF_US:        regs.holdoff_us = cfg_data;
          REG_PULSE_LEN_US:      regs.pulse_len_us = cfg_data[15:0];
          REG_AMPLITUDE_FLOOR:   regs.amplitude_floor = cfg_data[15:0];
          REG_CAPTURE_SPAN_US:   regs.capture_span_us = cfg_data;
          REG_SAMPLE_SPACING_US: regs.sample_spacing_us = cfg_data[15:0];
          REG_ZERO_LEVEL:        regs.zero_level = cfg_data[15:0];
          REG_IMBALANCE_LIMIT:   regs.imbalance_limit = cfg_data[15:0];
          default: ;  // unmapped index: drop the write
        endcase
      end
      if (result_valid && !result_stall) begin
        if (answers_due.size() == 0) begin
          $error("result_kind: expected no transfer, got 0x%0h", result_kind);
          bad++;
        end else begin
          want = answers_due.pop_front();
          bad += field_differs("result_kind", want.kind, result_kind);
          bad += field_differs("amplitude_out", want.amplitude, amplitude_out);
          bad += field_differs("buffer_taken", want.taken, buffer_taken);
          bad += field_differs("pulse", want.pulse, pulse);
          bad += field_differs("pulse_time_us", want.time_us, pulse_time_us);
          bad += field_differs("pulse_channel", want.channel, pulse_channel);
          bad += field_differs("pulse_width", want.width, pulse_width);
        end
      end
      if (item_valid && !item_stall) begin
        answers_due.push_back(predict_answer(kind, channel, end_time_us, amplitude,
                                             above_count, below_count, sample));
      end
    end
    failures <= failures + bad;
    outstanding <= answers_due.size();
  end

endmodule

// ===== tb/tb_rate_limited_zero_crossing_pulser.sv =====
module tb_rate_limited_zero_crossing_pulser
  import rlzc_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_CH = 4;
  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASES = 8;
  localparam int PHASE_ITEMS = 60;
  // an index past the register map; the block must drop writes to it
  localparam logic [CFG_IDX_W-1:0] UNMAPPED_REG = 4'd12;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0]          cfg_data = '0;

  logic        item_valid = 1'b0;
  logic        item_stall;
  logic        kind = 1'b0;
  logic [1:0]  channel = '0;
  logic [31:0] end_time_us = '0;
  logic [15:0] amplitude = '0;
  logic [15:0] above_count = '0;
  logic [15:0] below_count = '0;
  logic [15:0] sample = '0;

  logic        result_valid;
  logic        result_stall = 1'b0;
  logic        result_kind;
  logic [15:0] amplitude_out;
  logic        buffer_taken;
  logic        pulse;
  logic [31:0] pulse_time_us;
  logic [1:0]  pulse_channel;
  logic [15:0] pulse_width;

  int failures;
  int outstanding;

  int          cycle_count = 0;
  int          idle_pct = 0;
  int          stall_pct = 0;
  int          items_sent = 0;
  // newest end time handed to each channel, so fresh headers can be built
  logic [31:0] newest_end [NUM_CH] = '{default: '0};
  // live copies of the settings that shape samples and amplitudes
  logic [15:0] zero_now = RST_ZERO_LEVEL;
  logic [15:0] floor_now = RST_AMPLITUDE_FLOOR;

  rate_limited_zero_crossing_pulser #(.CHANNELS(NUM_CH)) DUT (.*);

  zero_crossing_checker #(.CHANNELS(NUM_CH)) u_checker (.*);

  always #5 clk = ~clk;

  // Receiver side: stall each cycle with the current odds.
  always @(posedge clk) begin
    result_stall <= ($urandom_range(99) < stall_pct);
  end

  // Watchdog: a hung handshake or a lost result ends here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Offer one item and hold it until it transfers. Valid stays high on return
  // so a back-to-back item needs no second assignment in the same step; the
  // idle loop drops it only when a gap is drawn.
  task automatic send_item(input logic k, input logic [1:0] ch, input logic [31:0] t,
      input logic [15:0] amp, input logic [15:0] above, input logic [15:0] below,
      input logic [15:0] smp);
    while ($urandom_range(99) < idle_pct) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid  <= 1'b1;
    kind        <= k;
    channel     <= ch;
    end_time_us <= t;
    amplitude   <= amp;
    above_count <= above;
    below_count <= below;
    sample      <= smp;
    do @(posedge clk); while (item_stall);
    items_sent++;
  endtask

  // Header transfer; the sample field is don't-care, so fill it with noise.
  task automatic send_header(input logic [1:0] ch, input logic [31:0] t,
      input logic [15:0] amp, input logic [15:0] above, input logic [15:0] below);
    send_item(KIND_HEADER, ch, t, amp, above, below, 16'($urandom));
    if (t > newest_end[ch]) newest_end[ch] = t;
  endtask

  // Sample transfer; header fields are don't-care, so fill them with noise.
  task automatic send_sample(input logic [15:0] smp);
    send_item(KIND_SAMPLE, 2'($urandom), $urandom, 16'($urandom), 16'($urandom),
              16'($urandom), smp);
  endtask

  task automatic configure(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // Drop valid and wait until every answer is back, then let the pipe empty.
  task automatic drain();
    item_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (4) @(posedge clk);
  endtask

  // Load a full register set; only called with the block idle.
  task automatic setup_phase(input int p);
    cfg_t cfg;
    case (p)
      // extremes: no floor, widest span and spacing, any imbalance is lopsided
      1: cfg = '{crossing_enable: 1'b1, holdoff_us: 32'd0, pulse_len_us: 16'hFFFF,
                 amplitude_floor: 16'd0, capture_span_us: 32'hFFFF_FFFF,
                 sample_spacing_us: 16'hFFFF, zero_level: 16'h8000,
                 imbalance_limit: 16'd0};
      // crossing detection off, floor at the top
      2: cfg = '{crossing_enable: 1'b0, holdoff_us: 32'd1000, pulse_len_us: 16'd250,
                 amplitude_floor: 16'hFFFF, capture_span_us: 32'd500,
                 sample_spacing_us: 16'd10, zero_level: 16'd2048,
                 imbalance_limit: 16'd50};
      // longest hold-off, zero at full scale, nothing counts as lopsided
      3: cfg = '{crossing_enable: 1'b1, holdoff_us: 32'hFFFF_FFFF, pulse_len_us: 16'd1,
                 amplitude_floor: 16'd100, capture_span_us: 32'd0,
                 sample_spacing_us: 16'd0, zero_level: 16'hFFFF,
                 imbalance_limit: 16'hFFFF};
      4: cfg = '{crossing_enable: 1'b1, holdoff_us: 32'd500, pulse_len_us: 16'd1234,
                 amplitude_floor: 16'd1000, capture_span_us: 32'd2000,
                 sample_spacing_us: 16'd25, zero_level: 16'd2048,
                 imbalance_limit: 16'd20};
      // zero at code 0: values never go positive
      5: cfg = '{crossing_enable: 1'b1, holdoff_us: 32'd40, pulse_len_us: 16'd0,
                 amplitude_floor: 16'd3277, capture_span_us: 32'h8000_0000,
                 sample_spacing_us: 16'd1, zero_level: 16'd0,
                 imbalance_limit: 16'd50};
      6: cfg = '{crossing_enable: 1'b1, holdoff_us: $urandom_range(200),
                 pulse_len_us: 16'($urandom), amplitude_floor: 16'($urandom_range(20000)),
                 capture_span_us: $urandom, sample_spacing_us: 16'($urandom),
                 zero_level: 16'($urandom_range(500, 60000)),
                 imbalance_limit: 16'($urandom_range(300))};
      default: cfg = '{crossing_enable: 1'b1, holdoff_us: 32'd10,
                       pulse_len_us: 16'd100, amplitude_floor: 16'd3277,
                       capture_span_us: 32'd100, sample_spacing_us: 16'd3,
                       zero_level: 16'd2048, imbalance_limit: 16'd50};
    endcase
    configure(REG_CROSSING_ENABLE, 32'(cfg.crossing_enable));
    configure(REG_HOLDOFF_US, cfg.holdoff_us);
    configure(REG_PULSE_LEN_US, 32'(cfg.pulse_len_us));
    configure(REG_AMPLITUDE_FLOOR, 32'(cfg.amplitude_floor));
    configure(REG_CAPTURE_SPAN_US, cfg.capture_span_us);
    configure(REG_SAMPLE_SPACING_US, 32'(cfg.sample_spacing_us));
    configure(REG_ZERO_LEVEL, 32'(cfg.zero_level));
    configure(REG_IMBALANCE_LIMIT, 32'(cfg.imbalance_limit));
    if (p == 6) configure(UNMAPPED_REG, $urandom);
    cfg_valid <= 1'b0;
    zero_now = cfg.zero_level;
    floor_now = cfg.amplitude_floor;
  endtask

  // Mostly whole buffers (fresh header, then samples hugging the zero level so
  // crossings happen), mixed with stale headers, stray samples and silence.
  task automatic run_traffic(input int count);
    int          stop_at;
    int          pick;
    int          level;
    logic [1:0]  ch;
    logic [15:0] above;
    logic [15:0] below;
    stop_at = items_sent + count;
    while (items_sent < stop_at) begin
      pick = $urandom_range(99);
      ch = 2'($urandom_range(NUM_CH - 1));
      if (pick < 70 && newest_end[ch] < 32'hFFFF_0000) begin
        if ($urandom_range(99) < 30) begin
          above = 16'($urandom);
          below = 16'($urandom);
        end else begin
          above = 16'($urandom_range(1000));
          level = int'(above) + int'($urandom_range(120)) - 60;
          below = (level < 0) ? 16'd0 : 16'(level);
        end
        send_header(ch, newest_end[ch] + $urandom_range(1, 4096),
                    16'($urandom_range(16'hFFFF, floor_now)), above, below);
        repeat ($urandom_range(1, 10)) begin
          if ($urandom_range(99) < 15) begin
            send_sample(16'($urandom));
          end else begin
            level = int'(zero_now) + int'($urandom_range(600)) - 300;
            if (level < 0) level = 0;
            if (level > 16'hFFFF) level = 16'hFFFF;
            send_sample(16'(level));
          end
        end
      end else if (pick < 80) begin
        // stale: end time at or before the stored one
        send_header(ch, $urandom_range(newest_end[ch], 0), 16'($urandom),
                    16'($urandom), 16'($urandom));
      end else if (pick < 90) begin
        send_sample(16'($urandom));
      end else begin
        // fresh but silent, so the samples after it must be ignored
        send_header(ch, newest_end[ch] + $urandom_range(1, 4096),
                    (floor_now == 0) ? 16'd0 : 16'($urandom_range(floor_now - 1)),
                    16'($urandom), 16'($urandom));
      end
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed part, reset settings: floor 3277, zero level 2048, limit 50,
    // no span, no spacing, no hold-off.
    send_sample(16'h0000);                                 // no buffer open yet
    send_header(2'd0, 32'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF); // end time equals stored: stale
    send_header(2'd1, 32'd100, 16'h0000, 16'd0, 16'd0);     // silent, end time still stored
    send_sample(16'h0000);                                 // ignored after silence
    send_header(2'd1, 32'd100, 16'd5000, 16'd0, 16'd0);     // same end time again: stale
    send_header(2'd1, 32'd200, 16'd3276, 16'd0, 16'd0);     // one below the floor
    send_header(2'd2, 32'd1000, 16'd3277, 16'd100, 16'd50); // at floor, diff at limit
    send_sample(16'd2048);                                 // value 0: no crossing
    send_sample(16'd2047);                                 // 0 -> 1: pulse
    send_sample(16'd2049);
    send_sample(16'h0000);                                 // -1 -> 2048: pulse
    send_sample(16'hFFFF);                                 // most negative value
    send_header(2'd3, 32'd2000, 16'd40000, 16'd0, 16'd51);  // lopsided buffer
    send_sample(16'd3000);
    send_sample(16'd2500);
    send_sample(16'd1000);                                 // rising trend: pulse
    send_sample(16'd2100);
    send_sample(16'd3000);
    send_sample(16'd100);                                  // falling trend: held back
    send_header(2'd0, 32'h0000_FFFF, 16'hFFFF, 16'hFFFF, 16'h0000);
    send_sample(16'h0000);
    send_sample(16'hFFFF);

    // Random part: cycle the idle profiles across register settings.
    for (int p = 0; p < PHASES; p++) begin
      if (p != 0) begin
        drain();
        setup_phase(p);
      end
      case (p % 4)
        0: begin idle_pct = 0;  stall_pct <= 0;  end
        1: begin idle_pct = 54; stall_pct <= 0;  end
        2: begin idle_pct = 0;  stall_pct <= 54; end
        default: begin idle_pct = 18; stall_pct <= 18; end
      endcase
      run_traffic(PHASE_ITEMS);
    end

    // Close out every channel at the last representable end time.
    for (int c = 0; c < NUM_CH; c++) begin
      send_header(2'(c), 32'hFFFF_FFFF, 16'hFFFF, 16'd0, 16'd0);
      send_sample(16'd3000);
      send_sample(16'd1000);
    end

    drain();
    if (failures == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/rlzc_pkg.sv
rtl/core/rlzc_cfg.sv
rtl/core/rlzc_chan_mem.sv
rtl/core/rate_limited_zero_crossing_pulser.sv
tb/zero_crossing_checker.sv
tb/tb_rate_limited_zero_crossing_pulser.sv
